// ===== hw/rtl/sle_pkg.sv =====
// Shared constants, codes and control types for the sorted list engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package sle_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_PRINT  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic capture;
        logic execute;
        logic print_next;
    } sle_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_print;
        logic multi;
        logic step_more;
    } sle_sts_t;

endpackage

// ===== hw/rtl/sle_if.sv =====
// Valid/ready channel interfaces for requests and responses of the sorted list engine.
// Depends on sle_pkg for field widths.
interface sle_req_if;
    logic                                valid;
    logic                                ready;
    logic        [sle_pkg::OP_W-1:0]     operation;
    logic signed [sle_pkg::VAL_W-1:0]    value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sle_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [sle_pkg::VAL_W-1:0]    entry;
    logic        [sle_pkg::ST_W-1:0]     status;
    logic                                last;

    modport source (output valid, output entry, output status, output last, input ready);
    modport sink   (input valid, input entry, input status, input last, output ready);
endinterface

// ===== hw/rtl/sle_ctrl.sv =====
// Controller state machine of the sorted list engine: sequences accept, execute and print.
// Depends on sle_pkg for the command and status structs.
module sle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sle_pkg::sle_sts_t sts,
    output sle_pkg::sle_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PRINT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        cmd.print_next = 1'b0;
        req_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = (sts.is_print && sts.multi) ? S_PRINT : S_IDLE;
                end
            end
            S_PRINT:
            begin
                if (sts.out_free)
                begin
                    cmd.print_next = 1'b1;
                    if (!sts.step_more)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.capture, cmd.execute, cmd.print_next}) <= 1)
        else $error("more than one datapath command at once");

    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("captured item not followed by execution");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRINT) |-> !req_ready)
        else $error("request accepted during a print");
`endif

endmodule

// ===== hw/rtl/sle_dp.sv =====
// Datapath of the sorted list engine: a chain of entry cells that compare and shift in
// parallel, the occupancy counter, the print index and the response register. Uses sle_pkg.
module sle_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sle_pkg::sle_cmd_t                   cmd,
    output sle_pkg::sle_sts_t                   sts,
    input  logic        [sle_pkg::OP_W-1:0]     req_operation,
    input  logic signed [sle_pkg::VAL_W-1:0]    req_value,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic signed [sle_pkg::VAL_W-1:0]    rsp_entry,
    output logic        [sle_pkg::ST_W-1:0]     rsp_status,
    output logic                                rsp_last
);

    logic signed [sle_pkg::VAL_W-1:0] entries_reg [sle_pkg::DEPTH];
    logic signed [sle_pkg::VAL_W-1:0] ins_next    [sle_pkg::DEPTH];
    logic signed [sle_pkg::VAL_W-1:0] del_next    [sle_pkg::DEPTH];
    logic        [sle_pkg::OP_W-1:0]  op_reg;
    logic signed [sle_pkg::VAL_W-1:0] val_reg;
    logic        [sle_pkg::CNT_W-1:0] occ_reg;
    logic        [sle_pkg::CNT_W-1:0] occ_next;
    logic        [sle_pkg::IDX_W-1:0] idx_reg;
    logic        [sle_pkg::IDX_W-1:0] idx_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic signed [sle_pkg::VAL_W-1:0] out_entry_reg;
    logic signed [sle_pkg::VAL_W-1:0] out_entry_next;
    logic        [sle_pkg::ST_W-1:0]  out_status_reg;
    logic        [sle_pkg::ST_W-1:0]  out_status_next;
    logic                             out_last_reg;
    logic                             out_last_next;

    logic [sle_pkg::DEPTH-1:0] lt;
    logic [sle_pkg::DEPTH-1:0] eq;
    logic [sle_pkg::DEPTH-1:0] past_hit;
    logic                      full;
    logic                      found;
    logic                      out_load;
    logic                      do_insert;
    logic                      do_delete;
    logic [sle_pkg::CNT_W-1:0] idx_ext;

    assign full    = (occ_reg == sle_pkg::CNT_W'(sle_pkg::DEPTH));
    assign idx_ext = sle_pkg::CNT_W'(idx_reg);

    always_comb
    begin
        for (int i = 0; i < sle_pkg::DEPTH; i++)
        begin
            lt[i] = (sle_pkg::CNT_W'(i) < occ_reg) && (entries_reg[i] < val_reg);
            eq[i] = (sle_pkg::CNT_W'(i) < occ_reg) && (entries_reg[i] == val_reg);
        end
        past_hit[0] = eq[0];
        for (int i = 1; i < sle_pkg::DEPTH; i++)
        begin
            past_hit[i] = past_hit[i-1] | eq[i];
        end
        found = past_hit[sle_pkg::DEPTH-1];

        ins_next[0] = lt[0] ? entries_reg[0] : val_reg;
        for (int i = 1; i < sle_pkg::DEPTH; i++)
        begin
            if (lt[i])
            begin
                ins_next[i] = entries_reg[i];
            end
            else if (lt[i-1])
            begin
                ins_next[i] = val_reg;
            end
            else
            begin
                ins_next[i] = entries_reg[i-1];
            end
        end

        for (int i = 0; i < sle_pkg::DEPTH - 1; i++)
        begin
            del_next[i] = past_hit[i] ? entries_reg[i+1] : entries_reg[i];
        end
        del_next[sle_pkg::DEPTH-1] = entries_reg[sle_pkg::DEPTH-1];
    end

    assign do_insert = cmd.execute && (op_reg == sle_pkg::OP_INSERT) && !full;
    assign do_delete = cmd.execute && (op_reg == sle_pkg::OP_DELETE) && found;

    always_comb
    begin
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        out_load        = 1'b0;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (cmd.execute)
        begin
            case (op_reg)
                sle_pkg::OP_INSERT:
                begin
                    out_load        = 1'b1;
                    out_entry_next  = val_reg;
                    out_last_next   = 1'b1;
                    out_status_next = full ? sle_pkg::ST_FULL : sle_pkg::ST_OK;
                    if (!full)
                    begin
                        occ_next = occ_reg + 1'b1;
                    end
                end
                sle_pkg::OP_DELETE:
                begin
                    out_load        = 1'b1;
                    out_entry_next  = val_reg;
                    out_last_next   = 1'b1;
                    out_status_next = found ? sle_pkg::ST_OK : sle_pkg::ST_NOT_FOUND;
                    if (found)
                    begin
                        occ_next = occ_reg - 1'b1;
                    end
                end
                sle_pkg::OP_PRINT:
                begin
                    out_load = 1'b1;
                    idx_next = sle_pkg::IDX_W'(1);
                    if (occ_reg == '0)
                    begin
                        out_entry_next  = '0;
                        out_status_next = sle_pkg::ST_EMPTY;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        out_entry_next  = entries_reg[0];
                        out_status_next = sle_pkg::ST_OK;
                        out_last_next   = (occ_reg == sle_pkg::CNT_W'(1));
                    end
                end
                default:
                begin
                    out_load = 1'b0;
                end
            endcase
        end
        else if (cmd.print_next)
        begin
            out_load        = 1'b1;
            out_entry_next  = entries_reg[idx_reg];
            out_status_next = sle_pkg::ST_OK;
            out_last_next   = (idx_ext + 1'b1 == occ_reg);
            idx_next        = idx_reg + 1'b1;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req_operation;
            val_reg <= req_value;
        end
        out_entry_reg  <= out_entry_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        for (int i = 0; i < sle_pkg::DEPTH; i++)
        begin
            if (do_insert)
            begin
                entries_reg[i] <= ins_next[i];
            end
            else if (do_delete)
            begin
                entries_reg[i] <= del_next[i];
            end
        end
    end

    assign sts.out_free  = !out_valid_reg || rsp_ready;
    assign sts.is_print  = (op_reg == sle_pkg::OP_PRINT);
    assign sts.multi     = (occ_reg > sle_pkg::CNT_W'(1));
    assign sts.step_more = (idx_ext + 1'b1 < occ_reg);

    assign rsp_valid  = out_valid_reg;
    assign rsp_entry  = out_entry_reg;
    assign rsp_status = out_status_reg;
    assign rsp_last   = out_last_reg;

`ifndef SYNTHESIS
    logic sorted_ok;

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 0; i < sle_pkg::DEPTH - 1; i++)
        begin
            if ((sle_pkg::CNT_W'(i + 1) < occ_reg) && (entries_reg[i] > entries_reg[i+1]))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= sle_pkg::CNT_W'(sle_pkg::DEPTH))
        else $error("occupancy beyond depth");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n) sorted_ok)
        else $error("stored entries out of ascending order");

    a_print_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.print_next |-> (idx_ext < occ_reg))
        else $error("print index past occupancy");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("insert did not grow occupancy");
`endif

endmodule

// ===== hw/rtl/sorted_list_engine.sv =====
// Top level of the sorted list engine: joins the controller and the cell-chain datapath
// to the request and response channels. Uses sle_pkg, sle_req_if and sle_rsp_if.
//
// The engine keeps up to sle_pkg::DEPTH signed 32-bit values in ascending order and takes
// one request at a time. An insert or a delete is accepted in S_IDLE and executed in
// S_EXEC, where every cell of the chain compares against the operand and shifts in
// parallel; it gives one response. A print gives one response per stored entry (one
// when the store is empty), streaming one response per cycle from the print index into
// the output register unless back-pressure on the response channel stalls it. A response
// may wait in the output register while the next request is taken.
module sorted_list_engine (
    input  logic   clk,
    input  logic   rst_n,
    sle_req_if.sink   req,
    sle_rsp_if.source rsp
);

    sle_pkg::sle_cmd_t cmd;
    sle_pkg::sle_sts_t sts;
    logic              req_ready;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sle_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_operation (req.operation),
        .req_value     (req.value),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_entry     (rsp.entry),
        .rsp_status    (rsp.status),
        .rsp_last      (rsp.last)
    );

    assign req.ready = req_ready;

endmodule
